### rtl/tet_negative_volume_fraction_core_assert.svh
// Assertion macros shared by the volume fraction pipeline modules.
`ifndef TET_NEGATIVE_VOLUME_FRACTION_CORE_ASSERT_SVH
`define TET_NEGATIVE_VOLUME_FRACTION_CORE_ASSERT_SVH

// Checked while reset is released.
`define TNVF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TNVF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tnvf_pkg.sv
// Shared types and constants of the tetrahedron volume fraction core.
package tnvf_pkg;

    // Width of one corner value field on the input stream.
    localparam int IN_FIELD_W = 16;
    // Width of the packed input transaction.
    localparam int S_TDATA_W  = 4 * IN_FIELD_W;

    // Which corners lie on the negative side after sorting.
    typedef enum logic [2:0] {
        CASE_ALL_IN,
        CASE_ALL_OUT,
        CASE_THREE_IN,
        CASE_TWO_IN,
        CASE_ONE_IN
    } case_t;

endpackage

### rtl/tnvf_sort.sv
// First pipeline stage: signed field read, four-value sorting network and case pick.
module tnvf_sort #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [tnvf_pkg::S_TDATA_W-1:0]    in_data,
    output logic                              out_valid,
    output logic signed [VALUE_WIDTH-1:0]     out_p [4],
    output tnvf_pkg::case_t                   out_case
);
    import tnvf_pkg::*;

    logic signed [VALUE_WIDTH-1:0] raw [4];
    logic signed [VALUE_WIDTH-1:0] lay1 [4];
    logic signed [VALUE_WIDTH-1:0] lay2 [4];
    logic signed [VALUE_WIDTH-1:0] p_next [4];
    logic signed [VALUE_WIDTH-1:0] p_reg [4];
    case_t                         case_next;
    case_t                         case_reg;
    logic                          valid_reg;

    // Keep the low bits of each field; they are read as two's complement.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            raw[i] = signed'(VALUE_WIDTH'(in_data[i*IN_FIELD_W +: IN_FIELD_W]));
        end
    end

    // Three layers of compare-and-swap give ascending order.
    always_comb begin
        lay1[0] = (raw[0] > raw[1]) ? raw[1] : raw[0];
        lay1[1] = (raw[0] > raw[1]) ? raw[0] : raw[1];
        lay1[2] = (raw[2] > raw[3]) ? raw[3] : raw[2];
        lay1[3] = (raw[2] > raw[3]) ? raw[2] : raw[3];
        lay2[0] = (lay1[0] > lay1[2]) ? lay1[2] : lay1[0];
        lay2[2] = (lay1[0] > lay1[2]) ? lay1[0] : lay1[2];
        lay2[1] = (lay1[1] > lay1[3]) ? lay1[3] : lay1[1];
        lay2[3] = (lay1[1] > lay1[3]) ? lay1[1] : lay1[3];
        p_next[0] = lay2[0];
        p_next[3] = lay2[3];
        p_next[1] = (lay2[1] > lay2[2]) ? lay2[2] : lay2[1];
        p_next[2] = (lay2[1] > lay2[2]) ? lay2[1] : lay2[2];
    end

    // A zero corner counts as negative when the case is picked.
    always_comb begin
        if (p_next[3] <= 0) begin
            case_next = CASE_ALL_IN;
        end else if (p_next[0] > 0) begin
            case_next = CASE_ALL_OUT;
        end else if (p_next[2] <= 0) begin
            case_next = CASE_THREE_IN;
        end else if (p_next[1] <= 0) begin
            case_next = CASE_TWO_IN;
        end else begin
            case_next = CASE_ONE_IN;
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            p_reg    <= p_next;
            case_reg <= case_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_p     = p_reg;
    assign out_case  = case_reg;

endmodule

### rtl/tnvf_poly.sv
// Stages two to five: factor setup, two multiplier levels and numerator assembly.
module tnvf_poly #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [VALUE_WIDTH-1:0]     in_p [4],
    input  tnvf_pkg::case_t                   in_case,
    output logic                              out_valid,
    output logic [4*VALUE_WIDTH+3:0]          out_num,
    output logic [4*VALUE_WIDTH+3:0]          out_den,
    output logic                              out_sat
);
    import tnvf_pkg::*;
    `include "tet_negative_volume_fraction_core_assert.svh"

    localparam int W  = VALUE_WIDTH;
    localparam int SW = 2 * W;
    localparam int PW = 2 * W + 2;
    localparam int NW = 4 * W + 4;

    // Stage two: multiplier operands and denominator factors.
    logic signed [W:0] ext [4];
    logic [W:0]        neg1;
    logic [W:0]        neg2;
    logic [W:0]        d21, d31, d41, d32, d42, d43;
    logic [W-1:0]      g_next [4];
    logic [W-1:0]      f_next [4];
    logic [W-1:0]      g_reg [4];
    logic [W-1:0]      f_reg [4];
    case_t             c2_reg;
    logic              v2_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ext[i] = {in_p[i][W-1], in_p[i]};
        end
        neg1 = (W+1)'(-ext[0]);
        neg2 = (W+1)'(-ext[1]);
        d21  = (W+1)'(ext[1] - ext[0]);
        d31  = (W+1)'(ext[2] - ext[0]);
        d41  = (W+1)'(ext[3] - ext[0]);
        d32  = (W+1)'(ext[2] - ext[1]);
        d42  = (W+1)'(ext[3] - ext[1]);
        d43  = (W+1)'(ext[3] - ext[2]);
        for (int i = 0; i < 4; i++) begin
            g_next[i] = '0;
            f_next[i] = W'(1);
        end
        case (in_case)
            CASE_THREE_IN: begin
                g_next[0] = W'(ext[3]);
                g_next[2] = W'(ext[3]);
                g_next[3] = W'(1);
                f_next[0] = d41[W-1:0];
                f_next[1] = d42[W-1:0];
                f_next[2] = d43[W-1:0];
            end
            CASE_TWO_IN: begin
                g_next[0] = neg1[W-1:0];
                g_next[1] = neg2[W-1:0];
                g_next[2] = W'(ext[2]);
                g_next[3] = W'(ext[3]);
                f_next[0] = d31[W-1:0];
                f_next[1] = d41[W-1:0];
                f_next[2] = d32[W-1:0];
                f_next[3] = d42[W-1:0];
            end
            CASE_ONE_IN: begin
                g_next[0] = neg1[W-1:0];
                g_next[2] = neg1[W-1:0];
                g_next[3] = W'(1);
                f_next[0] = d21[W-1:0];
                f_next[1] = d31[W-1:0];
                f_next[2] = d41[W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= in_valid;
        end
        if (en) begin
            g_reg  <= g_next;
            f_reg  <= f_next;
            c2_reg <= in_case;
        end
    end

    // Stage three: first multiplier level.
    logic [SW-1:0] s1_next, s2_next, s3_next, ab_next, d12_next, d34_next;
    logic [PW-1:0] sp_next;
    logic [SW-1:0] s1_reg, s2_reg, s3_reg, ab_reg, d12_reg, d34_reg;
    logic [PW-1:0] sp_reg;
    case_t         c3_reg;
    logic          v3_reg;

    always_comb begin
        s1_next  = SW'(g_reg[0]) * SW'(g_reg[0]);
        s2_next  = SW'(g_reg[0]) * SW'(g_reg[1]);
        s3_next  = SW'(g_reg[1]) * SW'(g_reg[1]);
        ab_next  = SW'(g_reg[2]) * SW'(g_reg[3]);
        sp_next  = (PW'(g_reg[0]) + PW'(g_reg[1])) * (PW'(g_reg[2]) + PW'(g_reg[3]));
        d12_next = SW'(f_reg[0]) * SW'(f_reg[1]);
        d34_next = SW'(f_reg[2]) * SW'(f_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            ab_reg  <= ab_next;
            sp_reg  <= sp_next;
            d12_reg <= d12_next;
            d34_reg <= d34_next;
            c3_reg  <= c2_reg;
        end
    end

    // Stage four: second multiplier level.
    logic [PW-1:0] qsum;
    logic [PW-1:0] rsum;
    logic [NW-1:0] y1_next, y2_next, den4_next;
    logic [NW-1:0] y1_reg, y2_reg, den4_reg;
    case_t         c4_reg;
    logic          v4_reg;

    always_comb begin
        qsum      = PW'(s1_reg) + PW'(s2_reg) + PW'(s3_reg);
        rsum      = sp_reg + PW'(s2_reg);
        y1_next   = NW'(qsum) * NW'(ab_reg);
        y2_next   = NW'(s2_reg) * NW'(rsum);
        den4_next = NW'(d12_reg) * NW'(d34_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            y1_reg   <= y1_next;
            y2_reg   <= y2_next;
            den4_reg <= den4_next;
            c4_reg   <= c3_reg;
        end
    end

    // Stage five: the three-in case takes the complement of the cube, other cases pass the sum; all-in is flagged.
    logic [NW-1:0] ysum;
    logic [NW-1:0] num_next;
    logic          sat_next;
    logic [NW-1:0] num_reg, den_reg;
    logic          sat_reg;
    logic          v5_reg;

    always_comb begin
        ysum     = y1_reg + y2_reg;
        num_next = (c4_reg == CASE_THREE_IN) ? den4_reg - ysum : ysum;
        sat_next = (c4_reg == CASE_ALL_IN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            num_reg <= num_next;
            den_reg <= den4_reg;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_sat   = sat_reg;

    `TNVF_ASSERT(a_den_nonzero, aclk, aresetn, v5_reg |-> den_reg != '0, "zero denominator")
    `TNVF_ASSERT(a_ratio_below_one, aclk, aresetn, (v5_reg && !sat_reg) |-> num_reg < den_reg, "ratio not below one")
    `TNVF_ASSERT(a_sat_num_zero, aclk, aresetn, (v5_reg && sat_reg) |-> num_reg == '0, "saturated item with numerator")

endmodule

### rtl/tnvf_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module tnvf_div #(
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [4*VALUE_WIDTH+3:0]      in_num,
    input  logic [4*VALUE_WIDTH+3:0]      in_den,
    input  logic                          in_sat,
    output logic                          out_valid,
    output logic [FRACTION_BITS:0]        out_frac
);
    localparam int NW = 4 * VALUE_WIDTH + 4;
    localparam int F  = FRACTION_BITS;

    logic [NW-1:0] rem_reg [F];
    logic [NW-1:0] den_reg [F];
    logic [F-1:0]  quo_reg [F];
    logic          sat_reg [F];
    logic          vld_reg [F];

    logic [NW-1:0] rem_in [F];
    logic [NW-1:0] den_in [F];
    logic [F-1:0]  quo_in [F];
    logic          sat_in [F];
    logic          vld_in [F];

    // Stage inputs come from the previous stage or from the ports.
    always_comb begin
        rem_in[0] = in_num;
        den_in[0] = in_den;
        quo_in[0] = '0;
        sat_in[0] = in_sat;
        vld_in[0] = in_valid;
        for (int k = 1; k < F; k++) begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            sat_in[k] = sat_reg[k-1];
            vld_in[k] = vld_reg[k-1];
        end
    end

    // Each stage doubles the remainder and subtracts the divisor when it fits.
    for (genvar k = 0; k < F; k++) begin : g_stage
        logic [NW:0]   dbl;
        logic          fits;
        logic [NW:0]   diff;
        logic [NW-1:0] rem_next;
        logic [F-1:0]  quo_next;

        always_comb begin
            dbl      = {rem_in[k], 1'b0};
            fits     = (dbl >= {1'b0, den_in[k]});
            diff     = dbl - {1'b0, den_in[k]};
            rem_next = fits ? diff[NW-1:0] : dbl[NW-1:0];
            quo_next = {quo_in[k][F-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next;
                sat_reg[k] <= sat_in[k];
            end
        end
    end

    // A whole-cell item reads as exactly one.
    assign out_valid = vld_reg[F-1];
    assign out_frac  = sat_reg[F-1] ? {1'b1, {F{1'b0}}} : {1'b0, quo_reg[F-1]};

endmodule

### rtl/tet_negative_volume_fraction_core.sv
// Pipeline: the sort stage, the factor, multiplier and numerator stages, then the divider stages.
// Throughput: one tetrahedron per cycle unless a held result stalls it; the divider has one stage per fraction bit.
// The whole pipeline holds while a result waits on m_tready, so nothing is lost.
// Reset: synchronous, active low; it clears every valid bit, payload is not reset.
// No memories, so the core accepts input as soon as reset is released.
module tet_negative_volume_fraction_core #(
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // value_a [15:0], value_b [31:16], value_c [47:32], value_d [63:48]
    input  logic [tnvf_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // negative_fraction [FRACTION_BITS:0], zero fill above
    output logic [((FRACTION_BITS+8)/8)*8-1:0]     m_tdata
);
    import tnvf_pkg::*;
    `include "tet_negative_volume_fraction_core_assert.svh"

    localparam int NW    = 4 * VALUE_WIDTH + 4;
    localparam int OUT_W = ((FRACTION_BITS + 8) / 8) * 8;

    logic                          en;
    logic                          sort_valid;
    logic signed [VALUE_WIDTH-1:0] sort_p [4];
    case_t                         sort_case;
    logic                          poly_valid;
    logic [NW-1:0]                 poly_num;
    logic [NW-1:0]                 poly_den;
    logic                          poly_sat;
    logic [FRACTION_BITS:0]        frac;

    // The pipeline advances unless a finished result is held by the sink.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    tnvf_sort #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (sort_valid),
        .out_p     (sort_p),
        .out_case  (sort_case)
    );

    tnvf_poly #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sort_valid),
        .in_p      (sort_p),
        .in_case   (sort_case),
        .out_valid (poly_valid),
        .out_num   (poly_num),
        .out_den   (poly_den),
        .out_sat   (poly_sat)
    );

    tnvf_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (poly_valid),
        .in_num    (poly_num),
        .in_den    (poly_den),
        .in_sat    (poly_sat),
        .out_valid (m_tvalid),
        .out_frac  (frac)
    );

    assign m_tdata = OUT_W'(frac);

    `TNVF_ASSERT(a_frac_range, aclk, aresetn, m_tvalid |-> frac <= {1'b1, {FRACTION_BITS{1'b0}}}, "fraction above one")
    `TNVF_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready), "input stalled without held result")
    `TNVF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

### test/tb_tet_negative_volume_fraction_core.sv
// Self-checking testbench for the tetrahedron negative volume fraction core.
module tb_tet_negative_volume_fraction_core;
    import tnvf_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int M_W         = ((FRAC_BITS + 8) / 8) * 8;
    localparam int LATENCY     = FRAC_BITS + 5;
    localparam int STALL_LIMIT = 3000;
    localparam int NUM_RANDOM  = 1630;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_W-1:0]       m_tdata;

    // Pending corner sets and the fractions still to come back.
    logic [S_TDATA_W-1:0] tet_queue[$];
    logic [M_W-1:0]       fraction_queue[$];
    bit                   stim_done = 1'b0;
    bit                   in_taken = 1'b0;
    int                   tets_sent = 0;
    int                   fractions_seen = 0;
    int                   errors = 0;
    int                   idle_cycles = 0;
    int                   holdoff = 0;
    bit                   holdoff_done = 1'b0;
    bit                   drain_done = 1'b0;
    int                   case_hits[5];

    tet_negative_volume_fraction_core dut (.*);

    always #5 aclk = ~aclk;

    // Exact negative-side volume fraction, truncated and saturated to Q1.16.
    function automatic logic [M_W-1:0] neg_fraction(input logic [S_TDATA_W-1:0] corners,
                                                    output case_t kind);
        longint      p[4];
        longint      tmp;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] u1;
        logic [127:0] u2;
        logic [127:0] a;
        logic [127:0] b;
        for (int i = 0; i < 4; i++)
            p[i] = longint'($signed(corners[i*IN_FIELD_W +: IN_FIELD_W]));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (p[j] > p[j+1]) begin
                    tmp = p[j]; p[j] = p[j+1]; p[j+1] = tmp;
                end
        if (p[3] <= 0) begin
            kind = CASE_ALL_IN;
            return M_W'(1 << FRAC_BITS);
        end
        if (p[0] > 0) begin
            kind = CASE_ALL_OUT;
            return '0;
        end
        if (p[2] <= 0) begin
            kind = CASE_THREE_IN;
            den = 128'(p[3] - p[0]) * 128'(p[3] - p[1]) * 128'(p[3] - p[2]);
            num = den - 128'(p[3]) * 128'(p[3]) * 128'(p[3]);
        end else if (p[1] <= 0) begin
            kind = CASE_TWO_IN;
            u1 = 128'(-p[0]); u2 = 128'(-p[1]); a = 128'(p[2]); b = 128'(p[3]);
            num = (u1*u1 + u1*u2 + u2*u2) * a * b + u1 * u2 * (u1 + u2) * (a + b)
                  + u1 * u1 * u2 * u2;
            den = (a + u1) * (b + u1) * (a + u2) * (b + u2);
        end else begin
            kind = CASE_ONE_IN;
            u1 = 128'(-p[0]);
            num = u1 * u1 * u1;
            den = 128'(p[1] - p[0]) * 128'(p[2] - p[0]) * 128'(p[3] - p[0]);
        end
        if (num >= den) return M_W'(1 << FRAC_BITS);
        return M_W'((num << FRAC_BITS) / den);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // Corner value with a chosen sign; zero counts as the negative side.
    function automatic int signed_val(bit neg, int span);
        int mag;
        mag = $urandom_range(span);
        return neg ? -mag : (mag == 0 ? 1 : mag);
    endfunction

    // Stimulus: directed corners, then random sets biased over the five cases.
    initial begin
        int kind;
        int span;
        int n_in;
        int v[4];
        tet_queue.push_back(pack(0, 0, 0, 0));
        tet_queue.push_back(pack(-32768, -32768, -32768, -32768));
        tet_queue.push_back(pack(32767, 32767, 32767, 32767));
        tet_queue.push_back(pack(1, 1, 1, 1));
        tet_queue.push_back(pack(-1, -1, -1, 1));
        tet_queue.push_back(pack(-32768, -32768, -32768, 32767));
        tet_queue.push_back(pack(0, 0, 0, 32767));
        tet_queue.push_back(pack(-32768, 1, 1, 1));
        tet_queue.push_back(pack(0, 32767, 32767, 32767));
        tet_queue.push_back(pack(-32768, 32767, 32767, 32767));
        tet_queue.push_back(pack(-1, -1, 1, 1));
        tet_queue.push_back(pack(-32768, -32768, 32767, 32767));
        tet_queue.push_back(pack(0, 0, 1, 1));
        tet_queue.push_back(pack(32767, -32768, 0, 1));
        tet_queue.push_back(pack(5, -3, 7, -2));
        tet_queue.push_back(pack(-32768, 0, 32767, 0));
        tet_queue.push_back(pack(-1, 0, 0, 1));
        tet_queue.push_back(pack(100, -100, 100, -100));
        tet_queue.push_back(pack(-1, 32767, 32767, 32767));
        tet_queue.push_back(pack(-32768, -32768, -32768, 1));
        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
                tet_queue.push_back({$urandom, $urandom});
            end else begin
                span = ($urandom_range(3) == 0) ? 8 : 32767;
                n_in = $urandom_range(4);
                for (int k = 0; k < 4; k++) v[k] = signed_val(k < n_in, span);
                // Shuffle so every corner position sees every sign.
                for (int k = 3; k > 0; k--) begin
                    int j;
                    int t;
                    j = $urandom_range(k);
                    t = v[k]; v[k] = v[j]; v[j] = t;
                end
                tet_queue.push_back(pack(v[0], v[1], v[2], v[3]));
            end
        end
    end

    // Hold reset from the start, then release it on a falling edge.
    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: presents the next corner set, idling now and then and pausing once to drain.
    always @(negedge aclk) begin
        if (aresetn && !stim_done && (!s_tvalid || in_taken)) begin
            if (tets_sent == 900 && !drain_done) begin
                // Hold input until every outstanding fraction has come back.
                s_tvalid <= 1'b0;
                if (fraction_queue.size() == 0) drain_done = 1'b1;
            end else if (tet_queue.size() == 0) begin
                s_tvalid <= 1'b0;
                stim_done = 1'b1;
            end else if ((tets_sent < 400 || tets_sent > 600) && $urandom_range(99) < 28) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= tet_queue.pop_front();
                s_tvalid <= 1'b1;
            end
        end
        in_taken = 1'b0;
    end

    // Receiver: random back-pressure, an always-ready window and one long hold-off.
    always @(negedge aclk) begin
        if (holdoff > 0) begin
            holdoff  = holdoff - 1;
            m_tready <= 1'b0;
        end else if (fractions_seen >= 300 && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff      = 200;
            m_tready     <= 1'b0;
        end else if (fractions_seen > 500 && fractions_seen < 700) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 28);
        end
    end

    // Monitor: predicts on input transactions, checks output transactions and ends the run if transactions stop.
    always @(posedge aclk) begin
        case_t       kind;
        logic [M_W-1:0] want;
        if (aresetn) begin
            idle_cycles = idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                fraction_queue.push_back(neg_fraction(s_tdata, kind));
                case_hits[kind] = case_hits[kind] + 1;
                tets_sent   = tets_sent + 1;
                in_taken    = 1'b1;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles    = 0;
                fractions_seen = fractions_seen + 1;
                if (fraction_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    errors = errors + 1;
                end else begin
                    want = fraction_queue.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: fraction mismatch, expected %h actual %h",
                                 $time, want, m_tdata);
                        errors = errors + 1;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_tet_negative_volume_fraction_core: errors");
                $finish;
            end
        end
    end

    // End of run: drain, settle, then report.
    initial begin
        wait (stim_done && fraction_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fraction_queue.size() != 0) errors = errors + fraction_queue.size();
        $display("Checked %0d tetrahedra, %0d fractions returned.", tets_sent, fractions_seen);
        $display("Cases: all in %0d, all out %0d, three in %0d, two in %0d, one in %0d.",
                 case_hits[CASE_ALL_IN], case_hits[CASE_ALL_OUT], case_hits[CASE_THREE_IN],
                 case_hits[CASE_TWO_IN], case_hits[CASE_ONE_IN]);
        if (errors == 0)
            $display("tb_tet_negative_volume_fraction_core: clean");
        else
            $display("tb_tet_negative_volume_fraction_core: errors");
        $finish;
    end
endmodule
